// ----- rtl/core/lphi_pkg.sv -----
// ----------------------------------------------------------------------------
// lphi_pkg
// Types and constants shared by the linear-probe hash insert block.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  // Largest entry count that still admits a new key is LOAD_MAX - 1.
  localparam int LOAD_MAX    = (3 * TABLE_SLOTS) / 4;

  localparam int KEY_W       = 32;
  localparam int HASH_W      = 32;
  localparam int VAL_W       = 64;
  localparam int IDX_OUT_W   = 8;
  localparam int CNT_OUT_W   = 9;

  typedef enum logic [1:0] {
    STATUS_UPDATED  = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_REFUSED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0]  entry_value;
  } lphi_in_t;

  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [CNT_OUT_W-1:0] entries_held;
  } lphi_out_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    logic    advance;
    logic    wr_insert;
    logic    wr_update;
    logic    load_result;
    status_e result_status;
  } lphi_cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic load_ok;
    logic probe_last;
  } lphi_stat_t;

endpackage

// ----- rtl/core/linear_probe_hash_insert_top.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_top
// Each probe is a registered read (S_READ) and then a compare (S_CHECK); the start
// slot is the low hash bits. One item is in flight at a time; the result register
// lets the next item start while a result waits, and its last probe holds until
// that is taken.
// Reset is asynchronous, active low, and clears all occupied marks and the count.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lphi_pkg::lphi_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lphi_pkg::lphi_out_t out_o
);
  import lphi_pkg::*;

  lphi_cmd_t  cmd;
  lphi_stat_t stat;

  lphi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lphi_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

// ----- rtl/core/lphi_datapath.sv -----
// ----------------------------------------------------------------------------
// lphi_datapath
// Item registers, start slot, slot memories, occupied marks, entry count and
// the result register.
// ----------------------------------------------------------------------------
module lphi_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lphi_pkg::lphi_in_t  in_i,
  input  lphi_pkg::lphi_cmd_t cmd_i,
  output lphi_pkg::lphi_stat_t stat_o,
  output lphi_pkg::lphi_out_t out_o
);
  import lphi_pkg::*;

  logic [KEY_W-1:0]     key_q;
  logic [VAL_W-1:0]     value_q;
  logic [SLOT_W-1:0]    start_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [SLOT_W-1:0]    probes_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;
  logic [TABLE_SLOTS-1:0] occ_q;
  logic                 rd_occ_q;
  logic [KEY_W-1:0]     rd_key_q;
  lphi_out_t            res_q;

  logic [KEY_W-1:0]     slot_keys   [TABLE_SLOTS];
  logic [VAL_W-1:0]     slot_values [TABLE_SLOTS];

  logic [SLOT_W-1:0]    res_idx;
  logic [SLOT_W+IDX_OUT_W-1:0] idx_ext;
  logic [CNT_W+CNT_OUT_W-1:0]  cnt_ext;

  assign count_d = cmd_i.wr_insert ? count_q + CNT_W'(1) : count_q;

  always_comb begin
    stat_o.hit        = rd_occ_q && (rd_key_q == key_q);
    stat_o.empty      = !rd_occ_q;
    stat_o.load_ok    = (count_q < CNT_W'(LOAD_MAX));
    stat_o.probe_last = (probes_q == SLOT_W'(TABLE_SLOTS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      occ_q   <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.wr_insert) begin
        occ_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      key_q    <= in_i.key_id;
      value_q  <= in_i.entry_value;
      // The slot count is a power of two, so the start slot is the low hash bits.
      start_q  <= in_i.key_hash[SLOT_W-1:0];
      idx_q    <= in_i.key_hash[SLOT_W-1:0];
      probes_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q    <= (idx_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_q + SLOT_W'(1);
      probes_q <= probes_q + SLOT_W'(1);
    end
    if (cmd_i.rd_en) begin
      rd_occ_q <= occ_q[idx_q];
    end
  end

  // Slot memories: one write port each; only the key memory has a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_insert) begin
      slot_keys[idx_q] <= key_q;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= slot_keys[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_insert || cmd_i.wr_update) begin
      slot_values[idx_q] <= value_q;
    end
  end

  assign res_idx = (cmd_i.result_status == STATUS_REFUSED) ? start_q : idx_q;
  assign idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_q.status       <= cmd_i.result_status;
      res_q.slot_index   <= idx_ext[IDX_OUT_W-1:0];
      res_q.entries_held <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_o = res_q;

endmodule

// ----- rtl/core/lphi_ctrl.sv -----
// ----------------------------------------------------------------------------
// lphi_ctrl
// Sequencer for the probe walk and the result handoff.
// ----------------------------------------------------------------------------
module lphi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lphi_pkg::lphi_stat_t stat_i,
  output lphi_pkg::lphi_cmd_t  cmd_o
);
  import lphi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.result_status = STATUS_REFUSED;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.hit || stat_i.empty || stat_i.probe_last) begin
          // The table is only changed when the result can be handed off.
          if (out_free) begin
            cmd_o.load_result = 1'b1;
            state_d = S_IDLE;
            if (stat_i.hit) begin
              cmd_o.wr_update     = 1'b1;
              cmd_o.result_status = STATUS_UPDATED;
            end else if (stat_i.empty && stat_i.load_ok) begin
              cmd_o.wr_insert     = 1'b1;
              cmd_o.result_status = STATUS_INSERTED;
            end
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_result ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/lphi_checker.sv -----
// ----------------------------------------------------------------------------
// lphi_checker
// Port-level checks for the linear-probe hash insert block.
// ----------------------------------------------------------------------------
module lphi_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lphi_pkg::lphi_out_t out_o
);
  import lphi_pkg::*;

  // One item at a time: the input closes right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.status == STATUS_UPDATED ||
                     out_o.status == STATUS_INSERTED ||
                     out_o.status == STATUS_REFUSED))
    else $error("result carries an unused status code");

  // Inserts never push the count beyond the load limit.
  a_load_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.entries_held <= CNT_OUT_W'(LOAD_MAX)))
    else $error("entry count above load limit");

  a_insert_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == STATUS_INSERTED) |-> (out_o.entries_held != '0))
    else $error("insert reported with zero entries");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result changed");

endmodule

bind linear_probe_hash_insert_top lphi_checker u_lphi_checker (.*);

// ----- tb/linear_probe_hash_insert_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_top_tb
// Drives keys, hashes and values into the hash insert block. A scoreboard keeps
// its own copy of the slot table and predicts status, slot and entry count for
// every accepted item. Both handshakes idle at random. The receiver also holds
// off once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_top_tb;
  import lphi_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int HOLD_AFTER     = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  class hash_table_scoreboard;
    logic [KEY_W-1:0] slot_key [TABLE_SLOTS];
    bit               slot_used [TABLE_SLOTS];
    int unsigned      held;
    lphi_out_t        pending_results [$];
    int unsigned      errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      held   = 0;
      errors = 0;
    endfunction

    // Walks the probe chain on the shadow table and queues the expected result.
    function void predict_insert(lphi_in_t item);
      int unsigned start;
      int unsigned idx;
      lphi_out_t   res;
      start          = item.key_hash % TABLE_SLOTS;
      idx            = start;
      res.status     = STATUS_REFUSED;
      res.slot_index = IDX_OUT_W'(start);
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (slot_used[idx]) begin
          if (slot_key[idx] == item.key_id) begin
            res.status     = STATUS_UPDATED;
            res.slot_index = IDX_OUT_W'(idx);
            break;
          end
        end else begin
          // A new key is taken only while the load stays at three quarters or below.
          if (4 * (held + 1) <= 3 * TABLE_SLOTS) begin
            slot_key[idx]  = item.key_id;
            slot_used[idx] = 1'b1;
            held++;
            res.status     = STATUS_INSERTED;
            res.slot_index = IDX_OUT_W'(idx);
          end
          break;
        end
        idx = (idx + 1) % TABLE_SLOTS;
      end
      res.entries_held = CNT_OUT_W'(held);
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    task check_result(lphi_out_t got);
      lphi_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d slot=%0d held=%0d",
                         got.status, got.slot_index, got.entries_held));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.slot_index !== want.slot_index)
          report($sformatf("slot_index %0d, expected %0d", got.slot_index, want.slot_index));
        if (got.entries_held !== want.entries_held)
          report($sformatf("entries_held %0d, expected %0d",
                           got.entries_held, want.entries_held));
      end
    endtask
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready_o;
  lphi_in_t  in_item   = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  lphi_out_t out_o;

  hash_table_scoreboard table_sb = new();
  int unsigned items_accepted = 0;
  int unsigned idle_cycles    = 0;
  logic [KEY_W-1:0]  known_key [$];
  logic [HASH_W-1:0] known_hash [$];

  linear_probe_hash_insert_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_i       (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_o      (out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic lphi_in_t make_item(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                                         logic [VAL_W-1:0] v);
    lphi_in_t item;
    item.key_id      = k;
    item.key_hash    = h;
    item.entry_value = v;
    return item;
  endfunction

  task automatic send_item(lphi_in_t item, bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Receiver: random ready bursts and stalls, plus one long hold-off.
  initial begin
    bit held_off;
    int gap;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && items_accepted >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        table_sb.predict_insert(in_item);
        items_accepted++;
      end
      if (out_valid_o && out_ready) table_sb.check_result(out_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("linear_probe_hash_insert_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    bit               no_gaps;
    int               mode;
    int               pick;
    logic [KEY_W-1:0]  k;
    logic [HASH_W-1:0] h;
    logic [VAL_W-1:0]  v;
    no_gaps = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners: slot 0 and slot 255, wrap past the last slot, updates, high hash bits.
    send_item(make_item('0, '0, '0), 1'b1);
    send_item(make_item('1, '1, '1), 1'b1);
    send_item(make_item(32'd5, 32'h0000_00ff, 64'h0123_4567_89ab_cdef), 1'b1);
    send_item(make_item('0, '0, 64'hdead_beef_0000_0001), 1'b1);
    send_item(make_item('1, '1, '0), 1'b1);
    send_item(make_item(32'd5, 32'h0000_00ff, '1), 1'b0);
    send_item(make_item(32'ha5a5_a5a5, 32'h5a5a_5a00, 64'h5555_aaaa_5555_aaaa), 1'b0);
    send_item(make_item('0, 32'h0000_0100, 64'h8000_0000_0000_0000), 1'b0);
    // Same key reached from another start slot is stored a second time.
    send_item(make_item('0, 32'h0000_0007, 64'h1), 1'b1);
    send_item(make_item(32'h8000_0000, 32'h8000_0080, 64'h7fff_ffff_ffff_ffff), 1'b1);
    send_item(make_item(32'h7fff_ffff, 32'hffff_ff00, 64'h0f0f_0f0f_f0f0_f0f0), 1'b1);
    send_item(make_item(32'h0000_0100, 32'h0000_00fe, 64'h2), 1'b1);
    send_item(make_item(32'h0000_0101, 32'h1234_56fe, 64'h3), 1'b1);
    send_item(make_item(32'h7fff_ffff, 32'hffff_ff00, 64'h4), 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 40 && known_key.size() > 0) begin
        pick = $urandom_range(0, known_key.size() - 1);
        k = known_key[pick];
        h = known_hash[pick];
      end else if (mode < 55) begin
        // Crowd new keys around a few start slots to build long probe chains.
        k = $urandom();
        h = {24'($urandom_range(0, 32'h00ff_ffff)), 8'd0};
        h[7:0] = 8'(($urandom_range(0, 3) * 64 + $urandom_range(0, 5)) % TABLE_SLOTS);
        known_key.push_back(k);
        known_hash.push_back(h);
      end else if (mode < 90) begin
        k = $urandom();
        h = $urandom();
        known_key.push_back(k);
        known_hash.push_back(h);
      end else if (known_key.size() > 0) begin
        // Known key offered with an unrelated hash.
        k = known_key[$urandom_range(0, known_key.size() - 1)];
        h = $urandom();
      end else begin
        k = $urandom();
        h = $urandom();
      end
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = {$urandom(), $urandom()};
      endcase
      send_item(make_item(k, h, v), !no_gaps);
    end
    in_valid <= 1'b0;

    while (table_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (table_sb.errors == 0) begin
      $display("linear_probe_hash_insert_top_tb: clean");
    end else begin
      $display("linear_probe_hash_insert_top_tb: errors");
    end
    $finish;
  end

endmodule
